// ===== rtl/mhpq_pkg.sv =====
// Shared types and codes for the max-heap priority queue unit.
// No dependencies; every other file imports this package.
package mhpq_pkg;

    // Default heap capacity.
    localparam int unsigned CAPACITY_DEF = 256;

    // Request codes.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // One request item.
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] push_value;
    } mhpq_in_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] top_value;
        logic [8:0]         entry_count;
        logic               is_empty;
        logic [1:0]         status;
    } mhpq_out_t;

endpackage

// ===== rtl/mhpq_ram.sv =====
// Heap store: one write port and one read port with registered read data.
// Depends on mhpq_pkg for the default capacity.
module mhpq_ram
    import mhpq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(CAPACITY)-1:0]  waddr,
    input  logic signed [31:0]           wdata,
    input  logic                         re,
    input  logic [$clog2(CAPACITY)-1:0]  raddr,
    output logic signed [31:0]           rdata
);

    logic signed [31:0] heap_mem [CAPACITY];
    logic signed [31:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
    end

    // Read port; read data is registered, so it appears in the cycle after the address.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= heap_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// Sequencer for push (sift up) and pop (sift down) over the heap store.
// Depends on mhpq_pkg for item types, request and status codes.
module mhpq_ctrl
    import mhpq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  mhpq_in_t                     s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output mhpq_out_t                    m_data,
    output logic                         ram_we,
    output logic [$clog2(CAPACITY)-1:0]  ram_waddr,
    output logic signed [31:0]           ram_wdata,
    output logic                         ram_re,
    output logic [$clog2(CAPACITY)-1:0]  ram_raddr,
    input  logic signed [31:0]           ram_rdata
);

    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned KW    = AW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_PL_WT,
        ST_DN_CHK,
        ST_DN_L,
        ST_DN_R,
        ST_FIN
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      pos_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] left_reg;
    logic [AW-1:0]      kid_reg;
    logic               has_r_reg;
    logic [CNT_W-1:0]   count_reg;
    logic signed [31:0] top_reg;
    logic [1:0]         status_reg;
    mhpq_out_t          res_reg;
    logic               m_valid_reg;

    logic [KW-1:0]      kid_w;
    logic [KW-1:0]      kidr_w;
    logic [KW-1:0]      cnt_w;
    logic               kid_in;
    logic               kidr_in;
    logic [AW-1:0]      pm1_w;
    logic [AW-1:0]      parent_w;
    logic [CNT_W-1:0]   cnt_m1_w;
    logic signed [31:0] big_w;
    logic [AW-1:0]      bidx_w;
    logic               sink_w;
    logic               accept_w;
    logic [CNT_W+8:0]   cnt_wide_w;

    // Index arithmetic for the current position.
    always_comb begin
        kid_w    = {1'b0, pos_reg, 1'b1};
        kidr_w   = kid_w + KW'(1);
        cnt_w    = KW'(count_reg);
        kid_in   = kid_w < cnt_w;
        kidr_in  = kidr_w < cnt_w;
        pm1_w    = pos_reg - AW'(1);
        parent_w = pm1_w >> 1;
        cnt_m1_w = count_reg - CNT_W'(1);
    end

    // Larger child: the left one alone, or the right one when strictly larger.
    always_comb begin
        if (state_reg == ST_DN_R && ram_rdata > left_reg) begin
            big_w  = ram_rdata;
            bidx_w = kid_reg + AW'(1);
        end else if (state_reg == ST_DN_R) begin
            big_w  = left_reg;
            bidx_w = kid_reg;
        end else begin
            big_w  = ram_rdata;
            bidx_w = kid_reg;
        end
        sink_w = big_w > val_reg;
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept_w = s_valid && s_ready;

    // Memory port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = val_reg;
        ram_re    = 1'b0;
        ram_raddr = parent_w;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept_w && s_data.req_type == REQ_POP && count_reg > CNT_W'(1)) begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_m1_w[AW-1:0];
                end
            end
            ST_UP_CHK: begin
                if (pos_reg == '0) begin
                    ram_we = 1'b1;
                end else begin
                    ram_re = 1'b1;
                end
            end
            ST_UP_CMP: begin
                ram_we = 1'b1;
                if (val_reg > ram_rdata) begin
                    ram_wdata = ram_rdata;
                end
            end
            ST_DN_CHK: begin
                if (!kid_in) begin
                    ram_we = 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = kid_w[AW-1:0];
                end
            end
            ST_DN_L: begin
                if (has_r_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = kid_reg + AW'(1);
                end else begin
                    ram_we = 1'b1;
                    if (sink_w) begin
                        ram_wdata = big_w;
                    end
                end
            end
            ST_DN_R: begin
                ram_we = 1'b1;
                if (sink_w) begin
                    ram_wdata = big_w;
                end
            end
            ST_PL_WT, ST_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // State, heap bookkeeping and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            if (ram_we && ram_waddr == '0) begin
                top_reg <= ram_wdata;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept_w) begin
                        val_reg <= s_data.push_value;
                        if (s_data.req_type == REQ_PUSH) begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                status_reg <= STAT_FULL;
                                state_reg  <= ST_FIN;
                            end else begin
                                status_reg <= STAT_OK;
                                pos_reg    <= count_reg[AW-1:0];
                                count_reg  <= count_reg + CNT_W'(1);
                                state_reg  <= ST_UP_CHK;
                            end
                        end else if (count_reg == '0) begin
                            status_reg <= STAT_EMPTY;
                            state_reg  <= ST_FIN;
                        end else begin
                            status_reg <= STAT_OK;
                            count_reg  <= cnt_m1_w;
                            state_reg  <= (count_reg == CNT_W'(1)) ? ST_FIN : ST_PL_WT;
                        end
                    end
                end
                ST_UP_CHK: begin
                    state_reg <= (pos_reg == '0) ? ST_FIN : ST_UP_CMP;
                end
                ST_UP_CMP: begin
                    if (val_reg > ram_rdata) begin
                        pos_reg   <= parent_w;
                        state_reg <= ST_UP_CHK;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_PL_WT: begin
                    val_reg   <= ram_rdata;
                    pos_reg   <= '0;
                    state_reg <= ST_DN_CHK;
                end
                ST_DN_CHK: begin
                    kid_reg   <= kid_w[AW-1:0];
                    has_r_reg <= kidr_in;
                    state_reg <= kid_in ? ST_DN_L : ST_FIN;
                end
                ST_DN_L: begin
                    left_reg <= ram_rdata;
                    if (has_r_reg) begin
                        state_reg <= ST_DN_R;
                    end else if (sink_w) begin
                        pos_reg   <= bidx_w;
                        state_reg <= ST_DN_CHK;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_DN_R: begin
                    if (sink_w) begin
                        pos_reg   <= bidx_w;
                        state_reg <= ST_DN_CHK;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        res_reg.top_value   <= (count_reg == '0) ? 32'sd0 : top_reg;
                        res_reg.entry_count <= cnt_wide_w[8:0];
                        res_reg.is_empty    <= (count_reg == '0);
                        res_reg.status      <= status_reg;
                        m_valid_reg         <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cnt_wide_w = {9'd0, count_reg};
    assign m_valid    = m_valid_reg;
    assign m_data     = res_reg;

    // The count never passes the capacity.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("heap count above capacity");

    // Writes land only inside the held part of the heap.
    a_write_held: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (CNT_W'(ram_waddr) < count_reg))
        else $error("heap write beyond held entries");

    // A read never meets a write to the same entry in one cycle.
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re && ram_waddr == ram_raddr))
        else $error("read and write of one entry in one cycle");

    // An accepted push into a heap with room grows the count by one.
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_w && s_data.req_type == REQ_PUSH && count_reg != CNT_W'(CAPACITY))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the count");

endmodule

// ===== rtl/max_heap_priority_queue_unit.sv =====
// Top level of the max-heap priority queue: sequencer plus heap store.
// Depends on mhpq_pkg, mhpq_ram and mhpq_ctrl.
//
//  Channel  Ports                       Moves
//  request  s_valid s_ready s_data      one push or pop item (mhpq_in_t)
//  result   m_valid m_ready m_data      one result item per request (mhpq_out_t)
//
// A push climbs one level per pass through ST_UP_CHK (read the parent) and
// ST_UP_CMP (compare and write), until it reaches the root or stops below; a
// pop reads the last entry, loads it in ST_PL_WT and sinks it one level per pass
// through ST_DN_CHK, ST_DN_L and, when a right child exists, ST_DN_R. Popping
// the last entry, a dropped push or an ignored pop goes straight to ST_FIN.
// The single read port of the heap store paces each level.
// Reset is synchronous; the store needs no clearing.
// A stalled result sits in the output register while the next item is
// accepted and worked on; that item then waits to finish until it is taken.
module max_heap_priority_queue_unit
    import mhpq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mhpq_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mhpq_out_t m_data
);

    localparam int unsigned AW = $clog2(CAPACITY);

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic signed [31:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic signed [31:0] ram_rdata;

    // Sift sequencer and result register.
    mhpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Heap store.
    mhpq_ram #(
        .CAPACITY (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== tb/sv/tb_max_heap_priority_queue_unit.sv =====
// Self-checking testbench for the max-heap priority queue unit.
// Depends on mhpq_pkg and on the RTL of max_heap_priority_queue_unit.
// A local heap model predicts every result; the sender and receiver idle and stall at random.
module tb_max_heap_priority_queue_unit;
    import mhpq_pkg::*;

    localparam int unsigned CAPACITY    = CAPACITY_DEF;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_WAIT  = 120;
    localparam int unsigned RANDOM_ITEMS = 950;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    mhpq_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    mhpq_out_t m_data;

    // Heap model and the results it has predicted.
    logic signed [31:0] model_heap [CAPACITY];
    int unsigned        model_count;
    mhpq_out_t          pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count;
    int unsigned burst_left;
    logic        hold_toggle;

    max_heap_priority_queue_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock with a period of 20.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Apply one request to the heap model and return the result it should give.
    function automatic mhpq_out_t heap_step(mhpq_in_t item);
        mhpq_out_t          res;
        int unsigned        pos;
        int unsigned        up;
        int unsigned        kid;
        logic signed [31:0] tmp;
        logic [1:0]         stat;
        stat = STAT_OK;
        if (item.req_type == REQ_PUSH) begin
            if (model_count >= CAPACITY) begin
                stat = STAT_FULL;
            end else begin
                pos = model_count;
                model_heap[pos] = item.push_value;
                model_count++;
                // Climb while strictly larger than the parent.
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (model_heap[pos] > model_heap[up]) begin
                        tmp = model_heap[pos];
                        model_heap[pos] = model_heap[up];
                        model_heap[up] = tmp;
                        pos = up;
                    end else begin
                        break;
                    end
                end
            end
        end else begin
            if (model_count == 0) begin
                stat = STAT_EMPTY;
            end else begin
                model_count--;
                model_heap[0] = model_heap[model_count];
                pos = 0;
                // Sink towards the larger child, the left one on a tie.
                forever begin
                    kid = pos * 2 + 1;
                    if (kid >= model_count) break;
                    if (kid + 1 < model_count && model_heap[kid + 1] > model_heap[kid])
                        kid++;
                    if (model_heap[kid] > model_heap[pos]) begin
                        tmp = model_heap[pos];
                        model_heap[pos] = model_heap[kid];
                        model_heap[kid] = tmp;
                        pos = kid;
                    end else begin
                        break;
                    end
                end
            end
        end
        res.top_value   = (model_count > 0) ? model_heap[0] : 32'sd0;
        res.entry_count = model_count[8:0];
        res.is_empty    = (model_count == 0);
        res.status      = stat;
        return res;
    endfunction

    // Value mix: full range, a narrow band that forces ties, and the extremes.
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6:          v = $signed($urandom_range(0, 15)) - 32'sd8;
            7:             v = 32'sh7fffffff;
            8:             v = 32'sh80000000;
            default:       v = $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                                    : 32'sh80000000 + $urandom_range(0, 3);
        endcase
        return v;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one item and hold it until accepted; the expected result is logged on acceptance.
    task automatic send_item(input logic req, input logic signed [31:0] val);
        mhpq_in_t item;
        item.req_type   = req;
        item.push_value = val;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(heap_step(item));
    endtask

    // Send an item and then, at the end of a burst, leave a random gap.
    task automatic send_paced(input logic req, input logic signed [31:0] val);
        int unsigned gap;
        send_item(req, val);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            // Now and then a long burst with no idling at all.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(0, 15);
        end
    endtask

    // Extremes, ties, every request kind and the empty-pop error case.
    task automatic test_directed();
        send_paced(REQ_POP,  32'sd0);
        send_paced(REQ_PUSH, 32'sd0);
        send_paced(REQ_PUSH, 32'sh7fffffff);
        send_paced(REQ_PUSH, 32'sh80000000);
        send_paced(REQ_PUSH, -32'sd1);
        send_paced(REQ_PUSH, 32'sd5);
        send_paced(REQ_PUSH, 32'sd5);
        send_paced(REQ_PUSH, 32'sd5);
        send_paced(REQ_PUSH, 32'sh7fffffff);
        repeat (4) send_paced(REQ_POP, $urandom);
        send_paced(REQ_PUSH, 32'sd1);
        send_paced(REQ_PUSH, 32'sd2);
        send_paced(REQ_PUSH, 32'sd3);
        repeat (7) send_paced(REQ_POP, $urandom);
        send_paced(REQ_POP, 32'sh7fffffff);
    endtask

    // Fill the heap to capacity, push into the full heap, then drain past empty.
    task automatic test_fill_and_drain();
        while (model_count < CAPACITY) send_paced(REQ_PUSH, pick_value());
        send_paced(REQ_PUSH, 32'sh7fffffff);
        send_paced(REQ_PUSH, 32'sh80000000);
        repeat (2) send_paced(REQ_PUSH, pick_value());
        while (model_count > 0) send_paced(REQ_POP, pick_value());
        repeat (2) send_paced(REQ_POP, pick_value());
    endtask

    // Random requests in phases of changing push bias.
    task automatic test_random_mix();
        int unsigned push_pct;
        int unsigned phase_left;
        phase_left = 0;
        push_pct   = 50;
        repeat (RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       push_pct = 90;
                    1:       push_pct = 20;
                    2:       push_pct = 65;
                    default: push_pct = 50;
                endcase
                phase_left = $urandom_range(50, 300);
            end
            phase_left--;
            if ($urandom_range(1, 100) <= push_pct)
                send_paced(REQ_PUSH, pick_value());
            else
                send_paced(REQ_POP, $urandom);
        end
    endtask

    // Hold the receiver off while the sender keeps offering items back to back.
    task automatic test_backpressure();
        hold_toggle <= ~hold_toggle;
        repeat (24) begin
            if ($urandom_range(0, 2) == 0)
                send_item(REQ_POP, $urandom);
            else
                send_item(REQ_PUSH, pick_value());
        end
    endtask

    // Receiver: long hold-offs on request, otherwise a changing stall pattern.
    initial begin : receiver
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned phase;
        logic        hold_seen;
        rx_mode_t    rx_mode;
        m_ready   = 1'b0;
        hold_left = 0;
        mode_left = 0;
        phase     = 0;
        hold_seen = 1'b0;
        rx_mode   = RX_ALWAYS;
        forever begin
            @(posedge aclk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 600);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_ready <= (phase % 7) > 2;
                    default:     m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        mhpq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", m_data.top_value, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.top_value !== want.top_value)
                    report_mismatch("top_value", m_data.top_value, want.top_value);
                if (m_data.entry_count !== want.entry_count)
                    report_mismatch("entry_count", m_data.entry_count, want.entry_count);
                if (m_data.is_empty !== want.is_empty)
                    report_mismatch("is_empty", m_data.is_empty, want.is_empty);
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
            end
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("max_heap_priority_queue_unit verification failed");
        $finish;
    end

    // Reset, the tests in turn, then drain and give the verdict.
    initial begin : sequencer
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        hold_toggle    = 1'b0;
        model_count    = 0;
        burst_left     = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_fill_and_drain();
        test_backpressure();
        test_random_mix();

        s_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("max_heap_priority_queue_unit verification clean");
        else
            $display("max_heap_priority_queue_unit verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_ctrl.sv
rtl/max_heap_priority_queue_unit.sv
tb/sv/tb_max_heap_priority_queue_unit.sv
